// ----- src/plu_pkg.sv -----
// Shared types, register codes and saturation helpers for the local polarization unit.
package plu_pkg;

  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned NumAxes  = 3;
  localparam int unsigned DivSteps = 60;

  localparam logic [CfgIdxW-1:0] RegBoxX   = 4'd0;
  localparam logic [CfgIdxW-1:0] RegBoxY   = 4'd1;
  localparam logic [CfgIdxW-1:0] RegBoxZ   = 4'd2;
  localparam logic [CfgIdxW-1:0] RegInvX   = 4'd3;
  localparam logic [CfgIdxW-1:0] RegInvY   = 4'd4;
  localparam logic [CfgIdxW-1:0] RegInvZ   = 4'd5;
  localparam logic [CfgIdxW-1:0] RegScale  = 4'd6;
  localparam logic [CfgIdxW-1:0] RegSites  = 4'd7;

  typedef enum logic [3:0] {
    StIdle,
    StDiff,
    StWrapN,
    StWrapM,
    StTerm,
    StScl0,
    StScl1,
    StScl2,
    StScl3,
    StDip,
    StOutSite,
    StDivInit,
    StDiv,
    StOutAvg
  } plu_state_e;

  function automatic logic signed [47:0] sat48(logic signed [60:0] v);
    logic signed [60:0] hi;
    logic signed [60:0] lo;
    hi = 61'sd140737488355327;
    lo = -61'sd140737488355328;
    if (v > hi) begin
      return 48'sh7FFF_FFFF_FFFF;
    end else if (v < lo) begin
      return 48'sh8000_0000_0000;
    end
    return v[47:0];
  endfunction

  function automatic logic signed [59:0] sat60(logic signed [60:0] v);
    if (v[60] != v[59]) begin
      return v[60] ? {1'b1, 59'd0} : {1'b0, {59{1'b1}}};
    end
    return v[59:0];
  endfunction

  // Rebuild a signed 48-bit value from sign and magnitude, saturated.
  function automatic logic signed [47:0] sm48(logic neg, logic [64:0] m);
    logic [47:0] mm;
    if (neg) begin
      mm = (m > 65'h8000_0000_0000) ? 48'h8000_0000_0000 : m[47:0];
      return 48'(-mm);
    end
    mm = (m > 65'h7FFF_FFFF_FFFF) ? 48'h7FFF_FFFF_FFFF : m[47:0];
    return mm;
  endfunction

endpackage

// ----- src/perovskite_local_polarization_unit.sv -----
// Local polarization unit: per-site Born-charge dipoles and frame averages.
//
// Input channel (in_valid_i/in_ready_o) takes one neighbor word: center and
// neighbor positions, effective charge, kind and a site-last flag. Output
// channel (out_valid_o/out_ready_i) returns a site dipole after each
// site-last word, followed by the frame average when the site closes a frame.
// Configuration is a plain write port (cfg_we_i, cfg_idx_i, cfg_wdata_i).
//
// One 33x32 multiplier is shared by every product. A neighbor word is
// accepted, then each axis runs difference, wrap-count, wrap and term
// steps. A site-last word adds scaling and a dipole step per axis before
// its result; a frame end adds the bit-serial divider before the average.
// The block takes one word at a time; in_ready_o is low until all results of
// the current word have been taken. A stalled receiver holds the result
// register and the whole block.
// Reset loads default box, reciprocal, scale and site-count registers and
// clears the site and frame accumulators and the site counter.
module perovskite_local_polarization_unit
  import plu_pkg::*;
#(
  parameter int unsigned MAX_SITES = 4096
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CfgIdxW-1:0]        cfg_idx_i,
  input  logic [CfgDataW-1:0]       cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      neighbor_kind_i,
  input  logic signed [31:0]        center_x_i,
  input  logic signed [31:0]        center_y_i,
  input  logic signed [31:0]        center_z_i,
  input  logic signed [31:0]        nbr_x_i,
  input  logic signed [31:0]        nbr_y_i,
  input  logic signed [31:0]        nbr_z_i,
  input  logic signed [23:0]        charge_x_i,
  input  logic signed [23:0]        charge_y_i,
  input  logic signed [23:0]        charge_z_i,
  input  logic                      site_last_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [47:0]        dipole_x_o,
  output logic signed [47:0]        dipole_y_o,
  output logic signed [47:0]        dipole_z_o,
  output logic                      is_frame_average_o,
  output logic                      run_last_o
);

  localparam int unsigned CntW = $clog2(MAX_SITES + 1);
  localparam int unsigned CmpW = (CntW > 13) ? CntW + 1 : 14;
  localparam logic [1:0] LastAxis = 2'(NumAxes - 1);
  localparam logic [5:0] LastDiv = 6'(DivSteps - 1);

  plu_state_e state_q, state_d;

  logic [30:0] box_q [NumAxes];
  logic [31:0] inv_q [NumAxes];
  logic [31:0] scale_q;
  logic [12:0] sites_q;

  logic               kind_q, last_q;
  logic signed [31:0] ctr_q [NumAxes];
  logic signed [31:0] nbr_q [NumAxes];
  logic signed [23:0] chg_q [NumAxes];

  logic signed [47:0] site_acc_q [NumAxes];
  logic signed [59:0] frame_acc_q [NumAxes];
  logic [CntW-1:0]    site_cnt_q;
  logic signed [47:0] out_q [NumAxes];

  logic [1:0]  axis_q;
  logic [32:0] tm_q, n_q;
  logic        tneg_q, dsgn_q, fend_q;
  logic [31:0] dmag_q;
  logic [64:0] acc_q;
  logic [CntW-1:0] rem_q;
  logic [59:0] quo_q;
  logic [5:0]  dcnt_q;

  logic [32:0] mul_a;
  logic [31:0] mul_b;
  logic [64:0] prod;
  logic        accept_in, accept_out;

  logic [23:0] qmag;
  logic [47:0] amag;
  logic        aneg;
  logic [CntW-1:0] divisor;
  logic [CmpW-1:0] eff, cnt_next;

  assign accept_in  = in_valid_i && in_ready_o;
  assign accept_out = out_valid_o && out_ready_i;

  assign qmag = chg_q[axis_q][23] ? 24'(-chg_q[axis_q]) : chg_q[axis_q];
  assign aneg = site_acc_q[axis_q][47];
  assign amag = aneg ? 48'(-site_acc_q[axis_q]) : site_acc_q[axis_q];
  assign divisor = CntW'(site_cnt_q + 1'b1);

  always_comb begin
    if (sites_q == 13'd0) begin
      eff = CmpW'(1);
    end else if (CmpW'(sites_q) > CmpW'(MAX_SITES)) begin
      eff = CmpW'(MAX_SITES);
    end else begin
      eff = CmpW'(sites_q);
    end
    cnt_next = CmpW'(site_cnt_q) + 1'b1;
  end

  // Shared multiplier operand select.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      StWrapN: begin
        mul_a = tm_q;
        mul_b = inv_q[axis_q];
      end
      StWrapM: begin
        mul_a = n_q;
        mul_b = {1'b0, box_q[axis_q]};
      end
      StTerm: begin
        mul_a = {1'b0, dmag_q};
        mul_b = {8'd0, qmag};
      end
      StScl0: begin
        mul_a = {9'd0, amag[23:0]};
        mul_b = {16'd0, scale_q[15:0]};
      end
      StScl1: begin
        mul_a = {9'd0, amag[47:24]};
        mul_b = {16'd0, scale_q[15:0]};
      end
      StScl2: begin
        mul_a = {9'd0, amag[23:0]};
        mul_b = {16'd0, scale_q[31:16]};
      end
      StScl3: begin
        mul_a = {9'd0, amag[47:24]};
        mul_b = {16'd0, scale_q[31:16]};
      end
      default: ;
    endcase
  end

  assign prod = {32'd0, mul_a} * {33'd0, mul_b};

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:    if (in_valid_i) state_d = StDiff;
      StDiff:    state_d = StWrapN;
      StWrapN:   state_d = StWrapM;
      StWrapM:   state_d = StTerm;
      StTerm: begin
        if (axis_q != LastAxis) begin
          state_d = StDiff;
        end else if (last_q) begin
          state_d = StScl0;
        end else begin
          state_d = StIdle;
        end
      end
      StScl0:    state_d = StScl1;
      StScl1:    state_d = StScl2;
      StScl2:    state_d = StScl3;
      StScl3:    state_d = StDip;
      StDip:     state_d = (axis_q == LastAxis) ? StOutSite : StScl0;
      StOutSite: begin
        if (out_ready_i) state_d = fend_q ? StDivInit : StIdle;
      end
      StDivInit: state_d = StDiv;
      StDiv: begin
        if (dcnt_q == LastDiv) state_d = (axis_q == LastAxis) ? StOutAvg : StDivInit;
      end
      StOutAvg:  if (out_ready_i) state_d = StIdle;
      default:   state_d = StIdle;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    in_ready_o         = (state_q == StIdle);
    out_valid_o        = (state_q == StOutSite) || (state_q == StOutAvg);
    is_frame_average_o = (state_q == StOutAvg);
    run_last_o         = (state_q == StOutAvg) || !fend_q;
  end

  assign dipole_x_o = out_q[0];
  assign dipole_y_o = out_q[1];
  assign dipole_z_o = out_q[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumAxes; k++) begin
        box_q[k] <= 31'd65536;
        inv_q[k] <= 32'd65536;
      end
      scale_q <= 32'd65536;
      sites_q <= 13'd64;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegBoxX:  box_q[0] <= cfg_wdata_i[30:0];
        RegBoxY:  box_q[1] <= cfg_wdata_i[30:0];
        RegBoxZ:  box_q[2] <= cfg_wdata_i[30:0];
        RegInvX:  inv_q[0] <= cfg_wdata_i;
        RegInvY:  inv_q[1] <= cfg_wdata_i;
        RegInvZ:  inv_q[2] <= cfg_wdata_i;
        RegScale: scale_q  <= cfg_wdata_i;
        RegSites: sites_q  <= cfg_wdata_i[12:0];
        default: ;
      endcase
    end
  end

  // Accumulators and counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumAxes; k++) begin
        site_acc_q[k]  <= '0;
        frame_acc_q[k] <= '0;
      end
      site_cnt_q <= '0;
      axis_q     <= '0;
      fend_q     <= 1'b0;
      dcnt_q     <= '0;
    end else begin
      case (state_q)
        StIdle: axis_q <= '0;
        StTerm: begin
          logic [37:0]        pm;
          logic signed [60:0] term, sum;
          pm   = kind_q ? 38'(prod >> 19) : 38'(prod >> 17);
          term = (dsgn_q ^ chg_q[axis_q][23]) ? -61'(pm) : 61'(pm);
          sum  = 61'(site_acc_q[axis_q]) + term;
          site_acc_q[axis_q] <= sat48(sum);
          axis_q <= (axis_q == LastAxis) ? 2'd0 : axis_q + 2'd1;
        end
        StDip: begin
          logic signed [47:0] dip;
          dip = sm48(aneg, acc_q);
          site_acc_q[axis_q]  <= '0;
          frame_acc_q[axis_q] <= sat60(61'(frame_acc_q[axis_q]) + 61'(dip));
          if (axis_q == LastAxis) begin
            axis_q <= '0;
            fend_q <= (cnt_next >= eff);
          end else begin
            axis_q <= axis_q + 2'd1;
          end
        end
        StOutSite: begin
          if (out_ready_i && !fend_q) site_cnt_q <= CntW'(cnt_next);
        end
        StDivInit: dcnt_q <= '0;
        StDiv: begin
          dcnt_q <= dcnt_q + 6'd1;
          if (dcnt_q == LastDiv) begin
            frame_acc_q[axis_q] <= '0;
            if (axis_q == LastAxis) begin
              axis_q     <= '0;
              site_cnt_q <= '0;
            end else begin
              axis_q <= axis_q + 2'd1;
            end
          end
        end
        StOutAvg: begin
          if (out_ready_i) fend_q <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        if (accept_in) begin
          kind_q   <= neighbor_kind_i;
          last_q   <= site_last_i;
          ctr_q[0] <= center_x_i;
          ctr_q[1] <= center_y_i;
          ctr_q[2] <= center_z_i;
          nbr_q[0] <= nbr_x_i;
          nbr_q[1] <= nbr_y_i;
          nbr_q[2] <= nbr_z_i;
          chg_q[0] <= charge_x_i;
          chg_q[1] <= charge_y_i;
          chg_q[2] <= charge_z_i;
        end
      end
      StDiff: begin
        logic signed [32:0] t;
        t = 33'(nbr_q[axis_q]) - 33'(ctr_q[axis_q]);
        tneg_q <= t[32];
        tm_q   <= t[32] ? 33'(-t) : t;
      end
      StWrapN: begin
        logic [64:0] rnd;
        rnd  = prod + 65'h8000_0000;
        n_q <= rnd[64:32];
      end
      StWrapM: begin
        logic [63:0] m, tm64, diff;
        logic        sg;
        logic [31:0] mg;
        m    = prod[63:0];
        tm64 = 64'(tm_q);
        if (tm64 >= m) begin
          diff = tm64 - m;
          sg   = tneg_q;
        end else begin
          diff = m - tm64;
          sg   = !tneg_q;
        end
        if (sg) begin
          mg = (diff > 64'h8000_0000) ? 32'h8000_0000 : diff[31:0];
        end else begin
          mg = (diff > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : diff[31:0];
        end
        dmag_q <= mg;
        dsgn_q <= sg && (mg != 32'd0);
      end
      StScl0: acc_q <= prod;
      StScl1: acc_q <= acc_q + (prod << 24);
      StScl2: acc_q <= (acc_q >> 16) + prod;
      StScl3: acc_q <= acc_q + (prod << 24);
      StDip:  out_q[axis_q] <= sm48(aneg, acc_q);
      StDivInit: begin
        rem_q <= '0;
        quo_q <= frame_acc_q[axis_q][59] ? 60'(-frame_acc_q[axis_q]) : frame_acc_q[axis_q];
      end
      StDiv: begin
        logic [CntW:0]   trial;
        logic [CntW-1:0] rem_n;
        logic [59:0]     quo_n;
        trial = {rem_q, quo_q[59]};
        if (trial >= (CntW+1)'(divisor)) begin
          rem_n = CntW'(trial - (CntW+1)'(divisor));
          quo_n = {quo_q[58:0], 1'b1};
        end else begin
          rem_n = CntW'(trial);
          quo_n = {quo_q[58:0], 1'b0};
        end
        rem_q <= rem_n;
        quo_q <= quo_n;
        if (dcnt_q == LastDiv) begin
          out_q[axis_q] <= sm48(frame_acc_q[axis_q][59], 65'(quo_n));
        end
      end
      default: ;
    endcase
  end

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input taken while a result is pending");

  a_avg_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_frame_average_o) |-> run_last_o)
    else $error("frame average not marked last");

  a_site_then_avg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_out && !run_last_o) |=> (!in_ready_o && !out_valid_o))
    else $error("frame average skipped after frame-ending site");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_in |-> (CmpW'(site_cnt_q) < CmpW'(MAX_SITES)))
    else $error("site counter beyond maximum");

endmodule
